FILE: src/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Item kinds, phase codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none
package owm_pkg;
   localparam int CountWidth = 10;

   typedef enum logic [2:0] {
      KIND_TICK = 3'd0, KIND_RESET = 3'd1, KIND_WRITE = 3'd2,
      KIND_READ = 3'd3, KIND_SFIRST = 3'd4, KIND_SNEXT = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      OP_IDLE = 3'd0, OP_RESET = 3'd1, OP_WRITE = 3'd2, OP_READ = 3'd3, OP_SEARCH = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0, PH_RLOW = 3'd1, PH_RWAIT = 3'd2, PH_RTAIL = 3'd3,
      PH_WSLOT = 3'd4, PH_RSLOT = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      STEP_ID = 2'd0, STEP_CMP = 2'd1, STEP_DIR = 2'd2, STEP_CMD = 2'd3
   } step_type;

   localparam logic [2:0] REG_RESET_LOW     = 3'd0;
   localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] REG_PRESENCE_TAIL = 3'd2;
   localparam logic [2:0] REG_WRITE_ONE     = 3'd3;
   localparam logic [2:0] REG_WRITE_ZERO    = 3'd4;
   localparam logic [2:0] REG_SLOT_TOTAL    = 3'd5;
   localparam logic [2:0] REG_READ_LOW      = 3'd6;
   localparam logic [2:0] REG_READ_SAMPLE   = 3'd7;

   localparam logic [7:0] SEARCH_ROM_CMD = 8'hF0;
   localparam logic [7:0] CRC_POLY       = 8'h8C;

   typedef struct packed {
      logic        drive_low;
      logic        done_res;
      logic        rejected;
      logic        presence;
      logic [7:0]  rx_byte;
      logic [63:0] rom_id;
      logic        found;
   } result_type;
endpackage
`default_nettype wire

FILE: src/owm_timing.sv
// ----------------------------------------------------------------------------
// owm_timing: duration registers of the bus master
// Holds the eight slot timings, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none
module owm_timing
   import owm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [2:0]            csr_index,
   input  wire logic [CountWidth-1:0] csr_wdata,
   output logic [7:0][CountWidth-1:0] timing
);
   logic [7:0][CountWidth-1:0] timing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff[REG_RESET_LOW]     <= CountWidth'(500);
         timing_ff[REG_PRESENCE_WAIT] <= CountWidth'(70);
         timing_ff[REG_PRESENCE_TAIL] <= CountWidth'(430);
         timing_ff[REG_WRITE_ONE]     <= CountWidth'(15);
         timing_ff[REG_WRITE_ZERO]    <= CountWidth'(60);
         timing_ff[REG_SLOT_TOTAL]    <= CountWidth'(65);
         timing_ff[REG_READ_LOW]      <= CountWidth'(5);
         timing_ff[REG_READ_SAMPLE]   <= CountWidth'(10);
      end else if (csr_we) begin
         timing_ff[csr_index] <= csr_wdata;
      end
   end

   assign timing = timing_ff;
endmodule
`default_nettype wire

FILE: src/one_wire_master_with_rom_search.sv
// ----------------------------------------------------------------------------
// one_wire_master_with_rom_search: 1-Wire bus master with ROM search
// Command and microsecond tick items in, one result item out per item.
// ----------------------------------------------------------------------------
// Usage: every req_ item is either a command (reset, write byte, read byte,
// search first, search next) or a tick that carries the sampled bus level.
// Each item yields exactly one rsp_ item. drive_low in that result is the pin
// drive to apply during the tick. A command given while another one runs is
// answered with rejected set and otherwise ignored.
// The item is processed into a result register and is offered on rsp_ in the
// next cycle. Throughput is one item per cycle; the next item is taken while
// a result is shown, as long as the result register empties in the same
// cycle or is already empty. If the receiver stalls, req_tready falls once
// the result register holds an item nobody has taken.
// Reset (synchronous, active high) restores the default timings, returns the
// sequencer to idle and empties the result register.
// tdata of req_: kind[2:0], tx_byte[10:3], bus_level[11], zero pad to 16 bits.
// tdata of rsp_: drive_low, done_res, rejected, presence, rx_byte, rom_id,
// found from bit 0 upward, zero pad to 80 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module one_wire_master_with_rom_search
   import owm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // kind, tx_byte, bus_level
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,  // drive_low, done_res, rejected, presence,
                                        // rx_byte, rom_id, found
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_wdata
);
   localparam int CW = CountWidth;

   logic [7:0][CW-1:0] timing;

   owm_timing u_timing (
      .clock, .reset, .csr_we, .csr_index,
      .csr_wdata(CW'(csr_wdata)), .timing
   );

   op_type     op_ff, op_in;
   phase_type  ph_ff, ph_in;
   step_type   step_ff, step_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [6:0] bit_ff, bit_in;
   logic [7:0] sb_ff, sb_in;
   logic [63:0] rom_ff, rom_in;
   logic [6:0] ld_ff, ld_in, lz_ff, lz_in;
   logic       ldev_ff, ldev_in, frb_ff, frb_in, pres_ff, pres_in;
   logic [7:0] crc_ff, crc_in;
   result_type res_ff, res_in;
   logic       rvalid_ff;

   logic       accept;
   logic [2:0] kind;
   logic [7:0] tx_byte;
   logic       lvl;

   assign req_tready = !rvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign kind       = req_tdata[2:0];
   assign tx_byte    = req_tdata[10:3];
   assign lvl        = req_tdata[11];

   function automatic logic [CW-1:0] span(input logic [CW-1:0] d);
      span = (d == '0) ? CW'(1) : d;
   endfunction

   always_comb begin
      logic [CW:0]   cnt1;
      logic [CW-1:0] slot, samp;
      logic          end_rlow, end_rwait, end_tail, end_slot;
      logic          dir, id, cmp, fb, o_done, o_found, rej, drv, present, slot_over;
      logic          search_end, search_ok, reset_over;
      logic [7:0]    o_rx, crc_t;
      logic [6:0]    n;

      op_in = op_ff; ph_in = ph_ff; step_in = step_ff; cnt_in = cnt_ff;
      bit_in = bit_ff; sb_in = sb_ff; rom_in = rom_ff; ld_in = ld_ff; lz_in = lz_ff;
      ldev_in = ldev_ff; frb_in = frb_ff; pres_in = pres_ff; crc_in = crc_ff;
      o_done = 1'b0; o_found = 1'b0; o_rx = '0; rej = 1'b0;
      search_end = 1'b0; search_ok = 1'b0; reset_over = 1'b0; present = 1'b0;
      slot_over = 1'b0; dir = 1'b0; id = 1'b0; cmp = 1'b0; fb = 1'b0;
      crc_t = '0; n = '0;

      cnt1 = {1'b0, cnt_ff} + 1'b1;
      slot = span(timing[REG_SLOT_TOTAL]);
      samp = (timing[REG_READ_SAMPLE] < slot) ? timing[REG_READ_SAMPLE] : slot - 1'b1;
      end_rlow  = cnt1 >= {1'b0, span(timing[REG_RESET_LOW])};
      end_rwait = cnt1 >= {1'b0, span(timing[REG_PRESENCE_WAIT])};
      end_tail  = cnt1 >= {1'b0, span(timing[REG_PRESENCE_TAIL])};
      end_slot  = cnt1 >= {1'b0, slot};

      case (ph_ff)
         PH_RLOW:  drv = 1'b1;
         PH_WSLOT: drv = cnt_ff < (sb_ff[0] ? timing[REG_WRITE_ONE]
                                            : timing[REG_WRITE_ZERO]);
         PH_RSLOT: drv = cnt_ff < timing[REG_READ_LOW];
         default:  drv = 1'b0;
      endcase

      if (kind == KIND_TICK) begin
         case (ph_ff)
            PH_RLOW: begin
               if (end_rlow) begin ph_in = PH_RWAIT; cnt_in = '0; end
               else cnt_in = cnt1[CW-1:0];
            end
            PH_RWAIT: begin
               if (end_rwait) begin ph_in = PH_RTAIL; cnt_in = '0; end
               else cnt_in = cnt1[CW-1:0];
            end
            PH_RTAIL: begin
               if (cnt_ff == '0 && lvl) begin
                  pres_in = 1'b0; reset_over = 1'b1; present = 1'b0;
               end else begin
                  if (cnt_ff == '0) pres_in = 1'b1;
                  if (end_tail) begin reset_over = 1'b1; present = 1'b1; end
                  else cnt_in = cnt1[CW-1:0];
               end
            end
            PH_WSLOT: begin
               if (end_slot) slot_over = 1'b1;
               else cnt_in = cnt1[CW-1:0];
            end
            PH_RSLOT: begin
               if (cnt_ff == samp) begin
                  if (op_ff == OP_READ) sb_in = {lvl, sb_ff[7:1]};
                  else if (step_ff == STEP_ID) frb_in = lvl;
                  else sb_in = {7'd0, lvl};
               end
               if (end_slot) slot_over = 1'b1;
               else cnt_in = cnt1[CW-1:0];
            end
            default: ;
         endcase

         if (reset_over) begin
            if (op_ff == OP_SEARCH) begin
               if (!present) search_end = 1'b1;
               else begin
                  sb_in = SEARCH_ROM_CMD; bit_in = '0; step_in = STEP_CMD;
                  ph_in = PH_WSLOT; cnt_in = '0;
               end
            end else begin
               op_in = OP_IDLE; ph_in = PH_IDLE; cnt_in = '0; o_done = 1'b1;
            end
         end

         if (slot_over) begin
            cnt_in = '0;
            if (op_ff == OP_WRITE || op_ff == OP_READ) begin
               if (op_ff == OP_WRITE) sb_in = {1'b0, sb_ff[7:1]};
               bit_in = bit_ff + 1'b1;
               if (bit_ff >= 7'd7) begin
                  if (op_ff == OP_READ) o_rx = sb_in;
                  op_in = OP_IDLE; ph_in = PH_IDLE; o_done = 1'b1;
               end
            end else begin
               case (step_ff)
                  STEP_CMD: begin
                     sb_in = {1'b0, sb_ff[7:1]};
                     if (bit_ff >= 7'd7) begin
                        bit_in = '0; step_in = STEP_ID; ph_in = PH_RSLOT;
                     end else begin
                        bit_in = bit_ff + 1'b1; ph_in = PH_WSLOT;
                     end
                  end
                  STEP_ID: begin step_in = STEP_CMP; ph_in = PH_RSLOT; end
                  STEP_CMP: begin
                     id = frb_ff; cmp = sb_in[0];
                     if (id && cmp) search_end = 1'b1;
                     else begin
                        n = bit_ff + 1'b1;
                        if (id != cmp) dir = id;
                        else begin
                           if (n < ld_ff) dir = rom_ff[bit_ff[5:0]];
                           else dir = (n == ld_ff);
                           if (!dir) lz_in = n;
                        end
                        rom_in[bit_ff[5:0]] = dir;
                        fb = crc_ff[0] ^ dir;
                        crc_t = {1'b0, crc_ff[7:1]};
                        crc_in = fb ? (crc_t ^ CRC_POLY) : crc_t;
                        sb_in = {7'd0, dir}; step_in = STEP_DIR; ph_in = PH_WSLOT;
                     end
                  end
                  default: begin
                     bit_in = bit_ff + 1'b1;
                     if (bit_ff >= 7'd63) begin
                        search_end = 1'b1; search_ok = (crc_ff == '0);
                     end else begin
                        step_in = STEP_ID; ph_in = PH_RSLOT;
                     end
                  end
               endcase
            end
         end
      end else if (kind <= KIND_SNEXT) begin
         if (op_ff != OP_IDLE) rej = 1'b1;
         else begin
            case (kind)
               KIND_RESET: begin op_in = OP_RESET; ph_in = PH_RLOW; cnt_in = '0; end
               KIND_WRITE, KIND_READ: begin
                  op_in = (kind == KIND_WRITE) ? OP_WRITE : OP_READ;
                  sb_in = (kind == KIND_WRITE) ? tx_byte : 8'd0;
                  bit_in = '0; cnt_in = '0;
                  ph_in = (kind == KIND_WRITE) ? PH_WSLOT : PH_RSLOT;
               end
               default: begin
                  if (kind == KIND_SFIRST) begin ld_in = '0; ldev_in = 1'b0; end
                  op_in = OP_SEARCH; crc_in = '0; lz_in = '0; bit_in = '0;
                  step_in = STEP_ID;
                  if (ldev_in) search_end = 1'b1;
                  else begin ph_in = PH_RLOW; cnt_in = '0; end
               end
            endcase
         end
      end

      if (search_end) begin
         if (search_ok) begin
            ld_in = lz_in;
            if (lz_in == '0) ldev_in = 1'b1;
            o_found = 1'b1;
         end
         if (!o_found || rom_in[7:0] == 8'd0) begin
            ld_in = '0; ldev_in = 1'b0; o_found = 1'b0;
         end
         op_in = OP_IDLE; ph_in = PH_IDLE; cnt_in = '0; o_done = 1'b1;
      end

      res_in.drive_low = drv;
      res_in.done_res  = o_done;
      res_in.rejected  = rej;
      res_in.presence  = pres_in;
      res_in.rx_byte   = o_rx;
      res_in.rom_id    = rom_in;
      res_in.found     = o_found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_IDLE; ph_ff <= PH_IDLE; step_ff <= STEP_ID; cnt_ff <= '0;
         bit_ff <= '0; sb_ff <= '0; rom_ff <= '0; ld_ff <= '0; lz_ff <= '0;
         ldev_ff <= 1'b0; frb_ff <= 1'b0; pres_ff <= 1'b0; crc_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (accept) begin
            op_ff <= op_in; ph_ff <= ph_in; step_ff <= step_in; cnt_ff <= cnt_in;
            bit_ff <= bit_in; sb_ff <= sb_in; rom_ff <= rom_in; ld_ff <= ld_in;
            lz_ff <= lz_in; ldev_ff <= ldev_in; frb_ff <= frb_in; pres_ff <= pres_in;
            crc_ff <= crc_in;
            rvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) res_ff <= res_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {3'd0, res_ff.found, res_ff.rom_id, res_ff.rx_byte, res_ff.presence,
                        res_ff.rejected, res_ff.done_res, res_ff.drive_low};

   // The sequencer is idle exactly when no phase is running.
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (op_ff == OP_IDLE) == (ph_ff == PH_IDLE))
      else $error("operation and phase disagree");

   // A result that was stalled must not be overwritten.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && !rsp_tready) |-> !accept)
      else $error("input taken over a stalled result");

   // A finished command always leaves the sequencer idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && res_in.done_res) |=> (op_ff == OP_IDLE))
      else $error("done reported while still busy");

   // Search bit position never passes the end of the ROM.
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= 7'd64)
      else $error("bit index out of range");
endmodule
`default_nettype wire

FILE: tb/sv/one_wire_master_with_rom_search_tb.sv
// ----------------------------------------------------------------------------
// one_wire_master_with_rom_search_tb: self-checking bench of the 1-Wire master
// Walks a short directed table and then runs random command sequences whose
// ticks come from a simulated bus with a few slave ROMs. Every result item is
// compared field by field with a row's given result or the bench's predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module one_wire_master_with_rom_search_tb;
   import owm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // kind[2:0], tx_byte[10:3], bus_level[11]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // drive_low, done_res, rejected, presence,
                                  // rx_byte, rom_id, found
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   one_wire_master_with_rom_search u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   logic [9:0]  timing [8];
   op_type      bus_op;
   phase_type   bus_phase;
   logic [9:0]  slot_tick;
   int          bit_pos;
   logic [7:0]  shifter;
   logic [63:0] rom_code;
   int          last_fork;
   bit          last_dev;
   int          zero_fork;
   logic [7:0]  crc_run;
   step_type    step;
   bit          id_bit;
   bit          presence_flag;
   bit          fin_done, fin_found;
   logic [7:0]  fin_rx;

   result_type  pending_results [$];
   int          mismatches = 0;
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;

   logic [63:0] slave_rom [4];
   int          slave_count = 1;

   function automatic int span_of(logic [9:0] d);
      return (d == 0) ? 1 : int'(d);
   endfunction

   function automatic bit phase_over(logic [9:0] d);
      return int'(slot_tick) + 1 >= span_of(d);
   endfunction

   function automatic void start_phase(phase_type p);
      bus_phase = p;
      slot_tick = '0;
   endfunction

   function automatic void finish_cmd();
      bus_op = OP_IDLE;
      start_phase(PH_IDLE);
      fin_done = 1'b1;
   endfunction

   function automatic void close_search(bit ok);
      if (ok) begin
         last_fork = zero_fork;
         if (last_fork == 0) last_dev = 1'b1;
         fin_found = 1'b1;
      end
      if (!fin_found || rom_code[7:0] == 8'h00) begin
         last_fork = 0;
         last_dev = 1'b0;
         fin_found = 1'b0;
      end
      finish_cmd();
   endfunction

   function automatic void reset_finished(bit present);
      if (bus_op == OP_SEARCH) begin
         if (!present) begin
            close_search(1'b0);
            return;
         end
         shifter = SEARCH_ROM_CMD;
         bit_pos = 0;
         step = STEP_CMD;
         start_phase(PH_WSLOT);
      end else begin
         finish_cmd();
      end
   endfunction

   function automatic bit drive_now();
      case (bus_phase)
         PH_RLOW:  return 1'b1;
         PH_WSLOT: return slot_tick < (shifter[0] ? timing[REG_WRITE_ONE]
                                                  : timing[REG_WRITE_ZERO]);
         PH_RSLOT: return slot_tick < timing[REG_READ_LOW];
         default:  return 1'b0;
      endcase
   endfunction

   function automatic void take_direction();
      bit cmp_bit, dir, fb;
      int n;
      cmp_bit = shifter[0];
      if (id_bit && cmp_bit) begin
         close_search(1'b0);
         return;
      end
      n = bit_pos + 1;
      if (id_bit != cmp_bit) begin
         dir = id_bit;
      end else begin
         if (n < last_fork) dir = rom_code[bit_pos & 63];
         else dir = (n == last_fork);
         if (!dir) zero_fork = n;
      end
      rom_code[bit_pos & 63] = dir;
      fb = crc_run[0] ^ dir;
      crc_run = crc_run >> 1;
      if (fb) crc_run ^= CRC_POLY;
      shifter = {7'd0, dir};
      step = STEP_DIR;
      start_phase(PH_WSLOT);
   endfunction

   function automatic void slot_finished();
      if (bus_op == OP_WRITE || bus_op == OP_READ) begin
         if (bus_op == OP_WRITE) shifter = shifter >> 1;
         bit_pos++;
         if (bit_pos >= 8) begin
            if (bus_op == OP_READ) fin_rx = shifter;
            finish_cmd();
         end else begin
            start_phase(bus_phase);
         end
         return;
      end
      case (step)
         STEP_CMD: begin
            shifter = shifter >> 1;
            bit_pos++;
            if (bit_pos >= 8) begin
               bit_pos = 0;
               step = STEP_ID;
               start_phase(PH_RSLOT);
            end else begin
               start_phase(PH_WSLOT);
            end
         end
         STEP_ID: begin
            step = STEP_CMP;
            start_phase(PH_RSLOT);
         end
         STEP_CMP: take_direction();
         default: begin
            bit_pos++;
            if (bit_pos >= 64) close_search(crc_run == 8'h00);
            else begin
               step = STEP_ID;
               start_phase(PH_RSLOT);
            end
         end
      endcase
   endfunction

   function automatic int sample_tick();
      int s;
      s = span_of(timing[REG_SLOT_TOTAL]);
      return (int'(timing[REG_READ_SAMPLE]) < s) ? int'(timing[REG_READ_SAMPLE]) : s - 1;
   endfunction

   function automatic void advance_tick(bit lvl);
      case (bus_phase)
         PH_RLOW:
            if (phase_over(timing[REG_RESET_LOW])) start_phase(PH_RWAIT);
            else slot_tick++;
         PH_RWAIT:
            if (phase_over(timing[REG_PRESENCE_WAIT])) start_phase(PH_RTAIL);
            else slot_tick++;
         PH_RTAIL: begin
            if (slot_tick == 0) begin
               presence_flag = !lvl;
               if (!presence_flag) begin
                  reset_finished(1'b0);
                  return;
               end
            end
            if (phase_over(timing[REG_PRESENCE_TAIL])) reset_finished(1'b1);
            else slot_tick++;
         end
         PH_WSLOT:
            if (phase_over(timing[REG_SLOT_TOTAL])) slot_finished();
            else slot_tick++;
         PH_RSLOT: begin
            if (int'(slot_tick) == sample_tick()) begin
               if (bus_op == OP_READ) shifter = {lvl, shifter[7:1]};
               else if (step == STEP_ID) id_bit = lvl;
               else shifter = {7'd0, lvl};
            end
            if (phase_over(timing[REG_SLOT_TOTAL])) slot_finished();
            else slot_tick++;
         end
         default: ;
      endcase
   endfunction

   function automatic result_type predict_item(logic [2:0] kind, logic [7:0] tx, bit lvl);
      result_type r;
      bit busy_reject;
      bit drv;
      busy_reject = 1'b0;
      drv = drive_now();
      fin_done = 1'b0;
      fin_rx = '0;
      fin_found = 1'b0;
      if (kind == KIND_TICK) begin
         advance_tick(lvl);
      end else if (kind <= KIND_SNEXT) begin
         if (bus_op != OP_IDLE) begin
            busy_reject = 1'b1;
         end else if (kind == KIND_RESET) begin
            bus_op = OP_RESET;
            start_phase(PH_RLOW);
         end else if (kind == KIND_WRITE || kind == KIND_READ) begin
            bus_op = (kind == KIND_WRITE) ? OP_WRITE : OP_READ;
            shifter = (kind == KIND_WRITE) ? tx : 8'h00;
            bit_pos = 0;
            start_phase(kind == KIND_WRITE ? PH_WSLOT : PH_RSLOT);
         end else begin
            if (kind == KIND_SFIRST) begin
               last_fork = 0;
               last_dev = 1'b0;
            end
            bus_op = OP_SEARCH;
            crc_run = '0;
            zero_fork = 0;
            bit_pos = 0;
            step = STEP_ID;
            if (last_dev) close_search(1'b0);
            else start_phase(PH_RLOW);
         end
      end
      r.drive_low = drv;
      r.done_res  = fin_done;
      r.rejected  = busy_reject;
      r.presence  = presence_flag;
      r.rx_byte   = fin_rx;
      r.rom_id    = rom_code;
      r.found     = fin_found;
      return r;
   endfunction

   // ---------------------------------------------------------------- bus model
   function automatic logic [7:0] crc8_bytes(logic [55:0] data);
      logic [7:0] c;
      bit fb;
      c = '0;
      for (int i = 0; i < 56; i++) begin
         fb = c[0] ^ data[i];
         c = c >> 1;
         if (fb) c ^= CRC_POLY;
      end
      return c;
   endfunction

   function automatic void new_slaves();
      logic [55:0] body;
      slave_count = $urandom_range(1, 4);
      for (int d = 0; d < 4; d++) begin
         body = 56'({$urandom, $urandom});
         if (body[7:0] == 8'h00) body[7:0] = 8'h28;
         slave_rom[d] = {crc8_bytes(body), body};
      end
   endfunction

   // Open-drain bus: the line reads low if any slave still in the search sends a zero.
   function automatic bit bus_level_now();
      logic [63:0] mask;
      bit id_and, cmp_and, lvl;
      if (bus_phase == PH_RTAIL && slot_tick == 0) begin
         lvl = ($urandom_range(9) == 0);
      end else if (bus_phase == PH_RSLOT && bus_op == OP_SEARCH) begin
         mask = (bit_pos >= 64) ? '1 : ((64'd1 << bit_pos) - 1);
         id_and = 1'b1;
         cmp_and = 1'b1;
         for (int d = 0; d < slave_count; d++) begin
            if ((slave_rom[d] & mask) == (rom_code & mask)) begin
               id_and &= slave_rom[d][bit_pos & 63];
               cmp_and &= !slave_rom[d][bit_pos & 63];
            end
         end
         lvl = (step == STEP_ID) ? id_and : cmp_and;
      end else begin
         lvl = $urandom_range(1);
      end
      if ($urandom_range(39) == 0) lvl = !lvl;
      return lvl;
   endfunction

   // ---------------------------------------------------------------- driving
   int items_sent = 0;

   task automatic send_item(logic [2:0] kind, logic [7:0] tx, bit lvl,
                            bit typed = 1'b0, result_type typed_result = '0);
      result_type r;
      r = predict_item(kind, tx, lvl);
      pending_results.push_back(typed ? typed_result : r);
      items_sent++;
      if (!calm && $urandom_range(5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, lvl, tx, kind};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, 8'($urandom), bus_level_now());
   endtask

   task automatic run_command(logic [2:0] kind, logic [7:0] tx);
      send_item(kind, tx, 1'($urandom));
      while (bus_op != OP_IDLE) begin
         if ($urandom_range(49) == 0) send_item(3'($urandom_range(1, 7)), 8'($urandom), 1'b0);
         else send_tick();
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_timing(logic [9:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         timing[i] = vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   typedef struct {
      logic [2:0] kind;
      logic [7:0] tx;
      bit         lvl;
      bit         typed;
      result_type want;
   } row_type;

   row_type directed [$];

   function automatic row_type row(logic [2:0] kind, logic [7:0] tx, bit lvl,
                                   bit typed = 1'b0, result_type want = '0);
      row_type t;
      t.kind = kind;
      t.tx = tx;
      t.lvl = lvl;
      t.typed = typed;
      t.want = want;
      return t;
   endfunction

   initial begin
      logic [9:0] vals [8];
      result_type busy;
      int phase_no;

      timing = '{10'd500, 10'd70, 10'd430, 10'd15, 10'd60, 10'd65, 10'd5, 10'd10};
      bus_op = OP_IDLE;
      bus_phase = PH_IDLE;
      slot_tick = '0;
      bit_pos = 0;
      shifter = '0;
      rom_code = '0;
      last_fork = 0;
      last_dev = 1'b0;
      zero_fork = 0;
      crc_run = '0;
      step = STEP_ID;
      id_bit = 1'b0;
      presence_flag = 1'b0;
      new_slaves();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: an idle tick and ignored kinds at the default timings first.
      busy = '0;
      busy.drive_low = 1'b1;
      busy.rejected = 1'b1;
      directed.push_back(row(KIND_TICK, 8'hFF, 1'b1, 1'b1, '0));
      directed.push_back(row(3'd6, 8'hFF, 1'b1, 1'b1, '0));
      directed.push_back(row(3'd7, 8'h00, 1'b0, 1'b1, '0));
      foreach (directed[i])
         send_item(directed[i].kind, directed[i].tx, directed[i].lvl,
                   directed[i].typed, directed[i].want);
      settle();

      // One-tick phases so every command fits in a few rows.
      vals = '{default: 10'd0};
      program_timing(vals);
      directed.delete();
      directed.push_back(row(KIND_RESET, 8'h00, 1'b0, 1'b1, '0));
      directed.push_back(row(KIND_WRITE, 8'hA5, 1'b0, 1'b1, busy));
      directed.push_back(row(KIND_TICK, 8'h00, 1'b1));
      directed.push_back(row(KIND_TICK, 8'h00, 1'b1));
      directed.push_back(row(KIND_TICK, 8'h00, 1'b0));
      directed.push_back(row(KIND_WRITE, 8'hFF, 1'b0));
      for (int i = 0; i < 8; i++) directed.push_back(row(KIND_TICK, 8'h00, 1'b1));
      directed.push_back(row(KIND_READ, 8'h00, 1'b0));
      for (int i = 0; i < 8; i++) directed.push_back(row(KIND_TICK, 8'h00, 1'(i)));
      foreach (directed[i])
         send_item(directed[i].kind, directed[i].tx, directed[i].lvl,
                   directed[i].typed, directed[i].want);
      while (bus_op != OP_IDLE) send_tick();
      settle();

      // Widest low times and sample tick against a short slot: the low time
      // is cut off at the slot's end and the sample falls on its last tick.
      vals = '{default: 10'h3FF};
      vals[REG_RESET_LOW] = 10'd2;
      vals[REG_PRESENCE_WAIT] = 10'd1;
      vals[REG_PRESENCE_TAIL] = 10'd2;
      vals[REG_SLOT_TOTAL] = 10'd3;
      program_timing(vals);
      run_command(KIND_RESET, 8'h00);
      run_command(KIND_WRITE, 8'h00);
      run_command(KIND_READ, 8'h00);
      settle();

      phase_no = 0;
      while (items_sent < 450 && phase_no < 60) begin
         for (int i = 0; i < 8; i++)
            vals[i] = ($urandom_range(7) == 0) ? 10'($urandom_range(0, 6))
                                               : 10'($urandom_range(0, 1));
         program_timing(vals);
         new_slaves();
         if (phase_no == 0) hold_request = 1'b1;
         if (items_sent > 350) calm = 1'b1;
         for (int n = 0; n < 3 && items_sent < 450; n++) begin
            case ($urandom_range(9))
               0:       send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
               1:       run_command(KIND_RESET, 8'h00);
               2:       run_command(KIND_WRITE, 8'($urandom));
               3:       run_command(KIND_READ, 8'h00);
               4, 5:    run_command(KIND_SFIRST, 8'h00);
               default: run_command(KIND_SNEXT, 8'h00);
            endcase
         end
         while (bus_op != OP_IDLE) send_tick();
         settle();
         phase_no++;
      end

      settle();
      repeat (6) @(posedge clock);
      if (mismatches == 0) $display("one_wire_master_with_rom_search_tb: PASS");
      else $display("one_wire_master_with_rom_search_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- checking
   function automatic void report(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endfunction

   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         report("unexpected item", '0, 64'(rsp_tdata));
         return;
      end
      want = pending_results.pop_front();
      if (rsp_tdata[0] !== want.drive_low) report("drive_low", want.drive_low, rsp_tdata[0]);
      if (rsp_tdata[1] !== want.done_res) report("done_res", want.done_res, rsp_tdata[1]);
      if (rsp_tdata[2] !== want.rejected) report("rejected", want.rejected, rsp_tdata[2]);
      if (rsp_tdata[3] !== want.presence) report("presence", want.presence, rsp_tdata[3]);
      if (rsp_tdata[11:4] !== want.rx_byte) report("rx_byte", want.rx_byte, rsp_tdata[11:4]);
      if (rsp_tdata[75:12] !== want.rom_id) report("rom_id", want.rom_id, rsp_tdata[75:12]);
      if (rsp_tdata[76] !== want.found) report("found", want.found, rsp_tdata[76]);
   endtask

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) check_result();
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            // Long hold-off so the result register fills and req_tready drops.
            hold_request = 1'b0;
            hold = 60;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(7) == 0) begin
            hold = $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= StallLimit) begin
            $display("one_wire_master_with_rom_search_tb: FAIL");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire

FILE: files.f
src/owm_pkg.sv
src/owm_timing.sv
src/one_wire_master_with_rom_search.sv
tb/sv/one_wire_master_with_rom_search_tb.sv
